/* hdl/bwfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwfl_pkg
// Shared types, constants and helpers of the byte window flood limiter.
// ----------------------------------------------------------------------------
package bwfl_pkg;

  // field widths
  localparam int TIME_W      = 32;
  localparam int LEN_W       = 10;
  localparam int IVL_W       = 8;
  localparam int LEAD_W      = 8;
  localparam int WIN_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // default number of table entries
  localparam int TABLE_DEPTH_DEF = 16;

  // len / 120 as (len * 1093) >> 17, exact for len below 1024
  localparam int RECIP_120   = 1093;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = 21;
  localparam int EXTRA_W     = 4;
  localparam int STEP_W      = 9;

  // register reset values
  localparam logic [IVL_W-1:0]  SEND_INTERVAL_RST = 8'd2;
  localparam logic [LEAD_W-1:0] MAX_LEAD_RST      = 8'd10;
  localparam logic [WIN_W-1:0]  WINDOW_BYTES_RST  = 16'd1024;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEND_INTERVAL = 2'd0,
    CFG_MAX_LEAD_TIME = 2'd1,
    CFG_WINDOW_BYTES  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [IVL_W-1:0]  send_interval;
    logic [LEAD_W-1:0] max_lead_time;
    logic [WIN_W-1:0]  window_bytes;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0]  msg_len;
    logic [TIME_W-1:0] now_sec;
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0] send_sec;
    logic [TIME_W-1:0] wait_sec;
    logic              window_waited;
  } res_t;

  typedef struct packed {
    logic [TIME_W-1:0] wake;
    logic [LEN_W-1:0]  bytes;
  } entry_t;

  // seconds add that sticks at the top value
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // extra seconds a message adds, len / 120
  function automatic logic [EXTRA_W-1:0] extra_secs(input logic [LEN_W-1:0] len);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(len) * PROD_W'(RECIP_120);
    return prod[RECIP_SHIFT +: EXTRA_W];
  endfunction

endpackage

/* hdl/byte_window_flood_limiter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_window_flood_limiter_core
// Send scheduler: pacing limit plus a byte window over recent messages,
// one send second per request.
// ----------------------------------------------------------------------------
//  channel   | handshake                   | beat
//  ----------+-----------------------------+------------------------------
//  request   | start high, busy low        | req_i   (msg_len, now_sec)
//  result    | done_o strobe, one cycle    | res_o   (send_sec, wait_sec,
//            |                             |          window_waited)
//  config    | cfg_valid_i and cfg_ready_o | cfg_index_i, cfg_data_i
//
//  a request makes a compaction pass before the window check and one more after
//  each window or full table wait, and at most one window walk over the table
//  memory, one entry read a cycle.
//  the result strobe follows in the cycle after the sequencer finishes; busy
//  is low in that cycle and a new request may start.
//  after reset the table is empty and pacing time is zero; no clearing pass.
//  the receiver cannot stall results; config is always ready.
// ----------------------------------------------------------------------------
module byte_window_flood_limiter_core #(
  parameter int TABLE_DEPTH = bwfl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  bwfl_pkg::req_t                      req_i,
  output logic                                done_o,
  output bwfl_pkg::res_t                      res_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bwfl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bwfl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int IW = bwfl_pkg::IVL_W;
  localparam int LW = bwfl_pkg::LEAD_W;
  localparam int WW = bwfl_pkg::WIN_W;

  bwfl_pkg::cfg_t cfg_q;
  bwfl_pkg::res_t res_q;
  bwfl_pkg::res_t ctrl_res;
  logic           done_q;
  logic           ctrl_done;
  logic           ctrl_busy;
  logic           req_accept;

  assign cfg_ready_o = 1'b1;
  assign req_accept  = start && !ctrl_busy;
  assign busy        = ctrl_busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.send_interval <= bwfl_pkg::SEND_INTERVAL_RST;
      cfg_q.max_lead_time <= bwfl_pkg::MAX_LEAD_RST;
      cfg_q.window_bytes  <= bwfl_pkg::WINDOW_BYTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bwfl_pkg::CFG_SEND_INTERVAL: cfg_q.send_interval <= cfg_data_i[IW-1:0];
        bwfl_pkg::CFG_MAX_LEAD_TIME: cfg_q.max_lead_time <= cfg_data_i[LW-1:0];
        bwfl_pkg::CFG_WINDOW_BYTES:  cfg_q.window_bytes  <= cfg_data_i[WW-1:0];
        default: ;
      endcase
    end
  end

  bwfl_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (req_accept),
    .req_i   (req_i),
    .cfg_i   (cfg_q),
    .busy_o  (ctrl_busy),
    .done_o  (ctrl_done),
    .res_o   (ctrl_res)
  );

  // result register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_done) begin
      res_q <= ctrl_res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  // a result beat comes out only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted request did not start work");
`endif

endmodule

/* hdl/bwfl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwfl_ctrl
// Sequencer with the entry table memory: pacing, expiry compaction passes,
// window walk, full table wait and append of the new entry.
// ----------------------------------------------------------------------------
module bwfl_ctrl #(
  parameter int TABLE_DEPTH = bwfl_pkg::TABLE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bwfl_pkg::req_t  req_i,
  input  bwfl_pkg::cfg_t  cfg_i,
  output logic            busy_o,
  output logic            done_o,
  output bwfl_pkg::res_t  res_o
);

  localparam int TW  = bwfl_pkg::TIME_W;
  localparam int LW  = bwfl_pkg::LEN_W;
  localparam int STW = bwfl_pkg::STEP_W;
  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SW  = CW + LW;
  localparam int NW  = (SW + 1 > bwfl_pkg::WIN_W + 1) ? SW + 1 : bwfl_pkg::WIN_W + 1;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_PACE    = 10'b00_0000_0010,
    S_LEAD    = 10'b00_0000_0100,
    S_DROP    = 10'b00_0000_1000,
    S_CHECK   = 10'b00_0001_0000,
    S_WALK    = 10'b00_0010_0000,
    S_WWAIT   = 10'b00_0100_0000,
    S_FULL    = 10'b00_1000_0000,
    S_FULL_RD = 10'b01_0000_0000,
    S_DONE    = 10'b10_0000_0000
  } state_e;

  // where a compaction pass returns to
  typedef enum logic [2:0] {
    PH_WIN  = 3'b001,
    PH_FULL = 3'b010,
    PH_DONE = 3'b100
  } phase_e;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  bwfl_pkg::req_t    req_q, req_d;
  logic [TW-1:0]     t_q, t_d;
  logic [TW-1:0]     pace_q, pace_d;
  logic [TW-1:0]     until_q, until_d;
  logic [STW-1:0]    step_q, step_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic [CW-1:0]     wr_idx_q, wr_idx_d;
  logic              pend_q, pend_d;
  logic [SW-1:0]     size_q, size_d;
  logic [NW-1:0]     need_q, need_d;
  logic              waited_q, waited_d;

  // entry table
  bwfl_pkg::entry_t  entry_mem [TABLE_DEPTH];
  bwfl_pkg::entry_t  rd_data_q;
  bwfl_pkg::entry_t  mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [AW-1:0]     mem_waddr;
  logic              mem_we;

  logic              issue;
  logic [TW-1:0]     lead;
  logic [NW-1:0]     total;
  logic [TW-1:0]     step_ext;

  assign issue    = (rd_idx_q != cnt_q);
  assign lead     = pace_q - req_q.now_sec;
  assign total    = NW'(size_q) + NW'(req_q.msg_len);
  assign step_ext = TW'(step_q);

  // memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= entry_mem[mem_raddr];
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    req_d     = req_q;
    t_d       = t_q;
    pace_d    = pace_q;
    until_d   = until_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    pend_d    = pend_q;
    size_d    = size_q;
    need_d    = need_q;
    waited_d  = waited_q;
    mem_we    = 1'b0;
    mem_raddr = '0;
    mem_waddr = wr_idx_q[AW-1:0];
    mem_wdata = rd_data_q;
    done_o    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d    = req_i;
          waited_d = 1'b0;
          state_d  = S_PACE;
        end
      end

      // raise pacing time to now, work out the step of this message
      S_PACE: begin
        if (pace_q < req_q.now_sec) begin
          pace_d = req_q.now_sec;
        end
        step_d  = STW'(cfg_i.send_interval) + STW'(bwfl_pkg::extra_secs(req_q.msg_len));
        state_d = S_LEAD;
      end

      // wait out the lead beyond the allowed one, then compact
      S_LEAD: begin
        if (lead > TW'(cfg_i.max_lead_time)) begin
          t_d = pace_q - TW'(cfg_i.max_lead_time);
        end else begin
          t_d = req_q.now_sec;
        end
        rd_idx_d = '0;
        wr_idx_d = '0;
        pend_d   = 1'b0;
        size_d   = '0;
        phase_d  = PH_WIN;
        state_d  = S_DROP;
      end

      // compaction pass: keep entries that wake after t, sum their bytes
      S_DROP: begin
        if (issue) begin
          mem_raddr = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
        end
        pend_d = issue;
        if (pend_q && (rd_data_q.wake > t_q)) begin
          mem_we   = 1'b1;
          wr_idx_d = wr_idx_q + CW'(1);
          size_d   = size_q + SW'(rd_data_q.bytes);
        end
        if (!pend_q && !issue) begin
          cnt_d = wr_idx_q;
          case (phase_q)
            PH_WIN:  state_d = S_CHECK;
            PH_FULL: state_d = S_FULL;
            default: state_d = S_DONE;
          endcase
        end
      end

      // byte window check
      S_CHECK: begin
        if (total >= NW'(cfg_i.window_bytes)) begin
          need_d   = total + NW'(1) - NW'(cfg_i.window_bytes);
          until_d  = t_q;
          rd_idx_d = '0;
          pend_d   = 1'b0;
          state_d  = S_WALK;
        end else begin
          state_d = S_FULL;
        end
      end

      // walk oldest first until enough bytes expire
      S_WALK: begin
        if (issue) begin
          mem_raddr = rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
        end
        pend_d = issue;
        if (pend_q) begin
          until_d = rd_data_q.wake;
          if (NW'(rd_data_q.bytes) >= need_q) begin
            state_d = S_WWAIT;
          end else begin
            need_d = need_q - NW'(rd_data_q.bytes);
          end
        end else if (!issue) begin
          state_d = S_WWAIT;
        end
      end

      S_WWAIT: begin
        if (t_q < until_q) begin
          t_d      = until_q;
          waited_d = 1'b1;
          rd_idx_d = '0;
          wr_idx_d = '0;
          pend_d   = 1'b0;
          size_d   = '0;
          phase_d  = PH_FULL;
          state_d  = S_DROP;
        end else begin
          state_d = S_FULL;
        end
      end

      // full table waits for its oldest entry
      S_FULL: begin
        if (cnt_q == CW'(TABLE_DEPTH)) begin
          mem_raddr = '0;
          state_d   = S_FULL_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      S_FULL_RD: begin
        if (t_q < rd_data_q.wake) begin
          t_d = rd_data_q.wake;
        end
        waited_d = 1'b1;
        rd_idx_d = '0;
        wr_idx_d = '0;
        pend_d   = 1'b0;
        size_d   = '0;
        phase_d  = PH_DONE;
        state_d  = S_DROP;
      end

      // advance pacing, append the entry, hand out the result
      S_DONE: begin
        pace_d = bwfl_pkg::sat_add(pace_q, step_ext);
        if (cnt_q != CW'(TABLE_DEPTH)) begin
          mem_we          = 1'b1;
          mem_waddr       = cnt_q[AW-1:0];
          mem_wdata.wake  = bwfl_pkg::sat_add(t_q, step_ext);
          mem_wdata.bytes = req_q.msg_len;
          cnt_d           = cnt_q + CW'(1);
        end
        done_o  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o              = (state_q != S_IDLE);
  assign res_o.send_sec      = t_q;
  assign res_o.wait_sec      = t_q - req_q.now_sec;
  assign res_o.window_waited = waited_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_WIN;
      pace_q   <= '0;
      cnt_q    <= '0;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      pend_q   <= 1'b0;
      waited_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      pace_q   <= pace_d;
      cnt_q    <= cnt_d;
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      pend_q   <= pend_d;
      waited_q <= waited_d;
    end
  end

  // working values
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    t_q     <= t_d;
    until_q <= until_d;
    step_q  <= step_d;
    size_q  <= size_d;
    need_q  <= need_d;
  end

`ifndef SYNTH
  // fill count never passes the table size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // compaction never writes ahead of what it has read
  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DROP) |-> (wr_idx_q <= rd_idx_q))
    else $error("compaction write index ahead of read index");

  // bytes still needed stay positive while walking
  a_need_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && pend_q) |-> (need_q != '0))
    else $error("window walk with nothing left to free");

  // every finished request leaves an entry behind
  a_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (cnt_q != '0))
    else $error("no entry appended after a request");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte window flood limiter core. A scoreboard
// class keeps its own model of pacing time and of the entry table. It works
// out the send second of every accepted request and checks each result beat
// against it in order. Directed requests cover the corner cases. After them
// come phases of random requests under several register settings and sender
// idle rates, which end with time pushed into saturation.
// ----------------------------------------------------------------------------

class flood_scoreboard;
  localparam int DEPTH               = bwfl_pkg::TABLE_DEPTH_DEF;
  localparam int BYTES_PER_EXTRA_SEC = 120;
  localparam int TIME_W              = bwfl_pkg::TIME_W;
  localparam int LEN_W               = bwfl_pkg::LEN_W;
  localparam int IVL_W               = bwfl_pkg::IVL_W;
  localparam int LEAD_W              = bwfl_pkg::LEAD_W;
  localparam int WIN_W               = bwfl_pkg::WIN_W;
  localparam int CFG_IDX_W           = bwfl_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W          = bwfl_pkg::CFG_DATA_W;

  logic [IVL_W-1:0]  send_interval;
  logic [LEAD_W-1:0] max_lead_time;
  logic [WIN_W-1:0]  window_bytes;

  logic [TIME_W-1:0] pace_sec;
  logic [TIME_W-1:0] wake_sec [DEPTH];
  logic [LEN_W-1:0]  held_bytes [DEPTH];
  int                held_count;

  bwfl_pkg::res_t due_sends[$];
  int             error_count;

  function new();
    send_interval = bwfl_pkg::SEND_INTERVAL_RST;
    max_lead_time = bwfl_pkg::MAX_LEAD_RST;
    window_bytes  = bwfl_pkg::WINDOW_BYTES_RST;
    pace_sec      = '0;
    held_count    = 0;
    error_count   = 0;
  endfunction

  // seconds sum that sticks at the top
  function logic [TIME_W-1:0] clamp_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return (a + b < a) ? {TIME_W{1'b1}} : a + b;
  endfunction

  // narrow registers keep only their low bits, unknown indexes do nothing
  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      bwfl_pkg::CFG_SEND_INTERVAL: send_interval = data[IVL_W-1:0];
      bwfl_pkg::CFG_MAX_LEAD_TIME: max_lead_time = data[LEAD_W-1:0];
      bwfl_pkg::CFG_WINDOW_BYTES:  window_bytes  = data[WIN_W-1:0];
      default: ;
    endcase
  endfunction

  // keep only entries still asleep at second t, oldest first
  function void drop_woken(logic [TIME_W-1:0] t);
    int kept;
    kept = 0;
    for (int i = 0; i < held_count; i++) begin
      if (wake_sec[i] > t) begin
        wake_sec[kept]   = wake_sec[i];
        held_bytes[kept] = held_bytes[i];
        kept++;
      end
    end
    held_count = kept;
  endfunction

  // schedule one accepted request and queue its send second
  function void note_request(bwfl_pkg::req_t r);
    logic [TIME_W-1:0] now, t, size, need, wake_at, step;
    logic              waited;
    bwfl_pkg::res_t    exp;
    now    = r.now_sec;
    t      = now;
    waited = 1'b0;

    // pacing
    if (pace_sec < now) pace_sec = now;
    if (pace_sec - now > TIME_W'(max_lead_time)) t = pace_sec - TIME_W'(max_lead_time);

    // byte window
    drop_woken(t);
    size = '0;
    for (int i = 0; i < held_count; i++) size += TIME_W'(held_bytes[i]);
    if (size + TIME_W'(r.msg_len) >= TIME_W'(window_bytes)) begin
      need    = size + TIME_W'(r.msg_len) + 1 - TIME_W'(window_bytes);
      wake_at = t;
      for (int i = 0; i < held_count; i++) begin
        wake_at = wake_sec[i];
        if (TIME_W'(held_bytes[i]) >= need) break;
        need -= TIME_W'(held_bytes[i]);
      end
      if (t < wake_at) begin
        t      = wake_at;
        waited = 1'b1;
        drop_woken(t);
      end
    end

    // a full table waits for its oldest entry
    if (held_count >= DEPTH) begin
      if (t < wake_sec[0]) t = wake_sec[0];
      waited = 1'b1;
      drop_woken(t);
    end

    step     = TIME_W'(send_interval) + TIME_W'(r.msg_len / BYTES_PER_EXTRA_SEC);
    pace_sec = clamp_add(pace_sec, step);
    if (held_count < DEPTH) begin
      wake_sec[held_count]   = clamp_add(t, step);
      held_bytes[held_count] = r.msg_len;
      held_count++;
    end

    exp.send_sec      = t;
    exp.wait_sec      = t - now;
    exp.window_waited = waited;
    due_sends.push_back(exp);
  endfunction

  // compare one result beat with the oldest scheduled send
  function void check_result(bwfl_pkg::res_t got);
    bwfl_pkg::res_t exp;
    if (due_sends.size() == 0) begin
      $error("result beat with no request pending: send_sec %0d", got.send_sec);
      error_count++;
      return;
    end
    exp = due_sends.pop_front();
    if (got.send_sec !== exp.send_sec) begin
      $error("send_sec: expected %0d, got %0d", exp.send_sec, got.send_sec);
      error_count++;
    end
    if (got.wait_sec !== exp.wait_sec) begin
      $error("wait_sec: expected %0d, got %0d", exp.wait_sec, got.wait_sec);
      error_count++;
    end
    if (got.window_waited !== exp.window_waited) begin
      $error("window_waited: expected %0b, got %0b", exp.window_waited,
             got.window_waited);
      error_count++;
    end
  endfunction

  function int pending();
    return due_sends.size();
  endfunction
endclass

module testbench;
  localparam int TIME_W     = bwfl_pkg::TIME_W;
  localparam int LEN_W      = bwfl_pkg::LEN_W;
  localparam int IVL_W      = bwfl_pkg::IVL_W;
  localparam int LEAD_W     = bwfl_pkg::LEAD_W;
  localparam int WIN_W      = bwfl_pkg::WIN_W;
  localparam int CFG_IDX_W  = bwfl_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = bwfl_pkg::CFG_DATA_W;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  bwfl_pkg::req_t        req_i;
  logic                  done_o;
  bwfl_pkg::res_t        res_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [TIME_W-1:0] wall_sec;
  flood_scoreboard   ledger = new();

  byte_window_flood_limiter_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result beats
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) ledger.check_result(res_o);
  end

  // run limit
  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bwfl_pkg::req_t make_req(logic [LEN_W-1:0] len,
                                               logic [TIME_W-1:0] now);
    bwfl_pkg::req_t r;
    r.msg_len = len;
    r.now_sec = now;
    return r;
  endfunction

  // one request beat, after a random idle gap; called and left at a falling edge
  task automatic send_request(input bwfl_pkg::req_t r, input int idle_pct);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk_i);
    req_i = r;
    start = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    ledger.note_request(r);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    ledger.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (ledger.pending() != 0) @(negedge clk_i);
  endtask

  // new register setting once idle; junk in the upper byte of narrow registers
  task automatic load_settings(input logic [IVL_W-1:0] ivl, input logic [LEAD_W-1:0] lead,
                               input logic [WIN_W-1:0] win);
    wait_drained();
    write_register(bwfl_pkg::CFG_SEND_INTERVAL, {8'($urandom), ivl});
    write_register(bwfl_pkg::CFG_MAX_LEAD_TIME, {8'($urandom), lead});
    if ($urandom_range(3) == 0) write_register(CFG_UNUSED_INDEX, 16'($urandom));
    write_register(bwfl_pkg::CFG_WINDOW_BYTES, win);
  endtask

  // random requests on a mostly rising clock of seconds
  task automatic random_phase(input int n_items, input int idle_pct, input int step_max,
                              input int len_cap);
    logic [LEN_W-1:0] len;
    wall_sec = ledger.clamp_add(wall_sec, 32'h0010_0000);
    for (int k = 0; k < n_items; k++) begin
      case ($urandom_range(9))
        0:       wall_sec = (wall_sec > 32'd3) ? wall_sec - 32'($urandom_range(3)) : wall_sec;
        1, 2:    ;
        default: wall_sec = ledger.clamp_add(wall_sec, 32'($urandom_range(step_max)));
      endcase
      case ($urandom_range(19))
        0:       len = '1;
        1:       len = '0;
        2, 3:    len = LEN_W'($urandom);
        4:       len = LEN_W'(120 * $urandom_range(8)) - LEN_W'($urandom_range(1));
        default: len = LEN_W'($urandom_range(len_cap));
      endcase
      send_request(make_req(len, wall_sec), idle_pct);
    end
  endtask

  initial begin
    logic [IVL_W-1:0]  ivl;
    logic [LEAD_W-1:0] lead;
    logic [WIN_W-1:0]  win;
    int                pct;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    wall_sec    = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: empty table, window fill, pacing lead over now
    send_request(make_req(10'd0, 32'd0), 0);
    send_request(make_req(10'd1023, 32'd0), 0);
    send_request(make_req(10'd1023, 32'd1), 0);
    send_request(make_req(10'd120, 32'd1), 0);

    // zero window: waits for the newest entry held, if any
    load_settings(8'd1, 8'd0, 16'd0);
    send_request(make_req(10'd10, 32'd200), 0);
    send_request(make_req(10'd10, 32'd200), 0);

    // message not smaller than the window, first on an empty table
    load_settings(8'd3, 8'd20, 16'd1);
    send_request(make_req(10'd1023, 32'd300), 0);
    send_request(make_req(10'd1, 32'd300), 0);
    send_request(make_req(10'd0, 32'd300), 0);

    // burst in one second until the table is full
    load_settings(8'd1, 8'd255, 16'hFFFF);
    for (int k = 0; k < bwfl_pkg::TABLE_DEPTH_DEF + 1; k++) begin
      send_request(make_req(10'd1, 32'd1000), 0);
    end

    wall_sec = 32'd1000;

    // low extremes of interval and lead, a one byte window
    load_settings(8'd0, 8'd0, 16'd1);
    random_phase(200, 78, 2, 1023);

    // short-lived small messages held still in time: table fills often
    load_settings(8'd1, 8'd255, 16'hFFFF);
    random_phase(300, 8, 1, 119);

    // tight window with a short lead
    load_settings(8'd5, 8'd3, 16'd2000);
    random_phase(300, 0, 8, 1023);

    // zero window
    load_settings(8'd1, 8'd20, 16'd0);
    random_phase(200, 78, 4, 1023);

    // random settings
    for (int p = 0; p < 6; p++) begin
      ivl  = IVL_W'($urandom);
      lead = LEAD_W'($urandom);
      win  = ($urandom_range(3) == 0) ? WIN_W'($urandom) : WIN_W'($urandom_range(4096, 256));
      case ($urandom_range(2))
        0:       pct = 0;
        1:       pct = 78;
        default: pct = 8;
      endcase
      load_settings(ivl, lead, win);
      random_phase(100, pct, $urandom_range(ivl / 8 + 3), ($urandom_range(1) == 0) ? 1023 : 119);
    end

    // top of time: sums saturate, pacing then sticks at the top for good
    load_settings(8'd255, 8'd200, 16'd3000);
    wall_sec = 32'hFFEF_FF00;
    random_phase(100, 0, 16, 1023);

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (ledger.pending() != 0) begin
      $error("%0d requests never produced a result", ledger.pending());
      ledger.error_count++;
    end
    if (ledger.error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/bwfl_pkg.sv
hdl/bwfl_ctrl.sv
hdl/byte_window_flood_limiter_core.sv
verif/testbench.sv
